// ===== rtl/golden_section_minimizer_defines.svh =====
// ----------------------------------------------------------------------------
// Golden-section minimiser assertion macros
// Shared property wrappers that the RTL uses for its concurrent checks.
// ----------------------------------------------------------------------------
`ifndef GOLDEN_SECTION_MINIMIZER_DEFINES_SVH
`define GOLDEN_SECTION_MINIMIZER_DEFINES_SVH

// Same-cycle implication, sampled on clk_i and quiet while rst_ni is low.
`define GSM_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("golden-section minimiser check failed");

// Next-cycle implication, sampled on clk_i and quiet while rst_ni is low.
`define GSM_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("golden-section minimiser check failed");

`endif

// ===== rtl/gsm_pkg.sv =====
// ----------------------------------------------------------------------------
// Golden-section minimiser package
// Data widths, status codes, register indexes and the golden-ratio constant.
// ----------------------------------------------------------------------------
`default_nettype none

package gsm_pkg;

  localparam int unsigned DATA_W      = 32;
  localparam int unsigned WIDTH_W     = 31;
  localparam int unsigned ITER_W      = 16;
  localparam int unsigned CFG_INDEX_W = 2;

  typedef logic signed [DATA_W-1:0] data_t;

  // 2 - phi, that is 0.381966..., as unsigned Q0.32.
  localparam logic [DATA_W-1:0] GOLD_Q32 = 32'd1640531527;

  typedef enum logic [2:0] {
    ST_CONVERGED    = 3'd0,
    ST_ITER_LIMIT   = 3'd1,
    ST_NOT_UNIMODAL = 3'd2,
    ST_INVALID      = 3'd3,
    ST_NO_SEARCH    = 3'd4
  } status_e;

  localparam logic [CFG_INDEX_W-1:0] REG_TOLERANCE = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_ITER  = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_MAXIMIZE  = 2'd2;

  localparam logic command_start = 1'b0;

endpackage

`default_nettype wire

// ===== rtl/golden_section_minimizer.sv =====
// ----------------------------------------------------------------------------
// Golden-section minimiser
// Runs a golden-section search in signed Q16.16, asking an outside evaluator
// for function values one point at a time.
// ----------------------------------------------------------------------------
// One word is taken on every clock cycle while result words are drained, and
// each word gives exactly one result word. An accepted word is captured in an
// input register. One pass of step logic then runs on it and its outcome
// lands in the result register, which drives the result word on the outputs.
// The step logic covers the interval update, a single 32 by 32 multiplier
// for the trial step and saturation. A result word that is still waiting
// holds the step, and the input register then stays full. The search
// itself advances at the pace of the outside evaluator, one returned value
// per step.
`default_nettype none

`include "golden_section_minimizer_defines.svh"

module golden_section_minimizer (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_we_i,
  input  wire logic [gsm_pkg::CFG_INDEX_W-1:0]     cfg_index_i,
  input  wire logic [gsm_pkg::WIDTH_W-1:0]         cfg_wdata_i,
  input  wire logic                                in_valid_i,
  output logic                                     in_ready_o,
  input  wire logic                                command_i,
  input  wire logic signed [gsm_pkg::DATA_W-1:0]   bound_low_i,
  input  wire logic signed [gsm_pkg::DATA_W-1:0]   bound_high_i,
  input  wire logic signed [gsm_pkg::DATA_W-1:0]   func_value_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_ready_i,
  output logic                                     finished_o,
  output logic signed [gsm_pkg::DATA_W-1:0]        point_o,
  output logic [2:0]                               status_o,
  output logic [gsm_pkg::WIDTH_W-1:0]              interval_width_o
);

  localparam int unsigned DW = gsm_pkg::DATA_W;
  localparam int unsigned WW = gsm_pkg::WIDTH_W;
  localparam int unsigned IW = gsm_pkg::ITER_W;

  localparam logic [2:0] PH_IDLE       = 3'd0;
  localparam logic [2:0] PH_WANT_LOW   = 3'd1;
  localparam logic [2:0] PH_WANT_HIGH  = 3'd2;
  localparam logic [2:0] PH_WANT_MID   = 3'd3;
  localparam logic [2:0] PH_WANT_TRIAL = 3'd4;

  localparam gsm_pkg::data_t DATA_MAX = {1'b0, {(DW-1){1'b1}}};
  localparam gsm_pkg::data_t DATA_MIN = {1'b1, {(DW-1){1'b0}}};
  localparam logic [2*DW-1:0] ROUND_HALF = (2*DW)'(1) << (DW - 1);

  function automatic logic [WW-1:0] sat_width(gsm_pkg::data_t lo, gsm_pkg::data_t hi);
    logic signed [DW:0] diff;
    diff = {hi[DW-1], hi} - {lo[DW-1], lo};
    if (diff[DW]) begin
      sat_width = '0;
    end else if (diff[DW-1:WW] != '0) begin
      sat_width = {WW{1'b1}};
    end else begin
      sat_width = diff[WW-1:0];
    end
  endfunction

  function automatic gsm_pkg::data_t make_trial(gsm_pkg::data_t lo, gsm_pkg::data_t mid,
                                                gsm_pkg::data_t hi);
    logic signed [DW:0]   wl;
    logic signed [DW:0]   wu;
    logic                 up;
    logic [DW-1:0]        mag;
    logic [2*DW-1:0]      prod;
    logic [DW-1:0]        step;
    logic signed [DW+1:0] sum;
    wl   = {mid[DW-1], mid} - {lo[DW-1], lo};
    wu   = {hi[DW-1], hi} - {mid[DW-1], mid};
    up   = wu > wl;
    mag  = up ? wu[DW-1:0] : wl[DW-1:0];
    prod = (2*DW)'(mag) * (2*DW)'(gsm_pkg::GOLD_Q32) + ROUND_HALF;
    step = prod[2*DW-1:DW];
    if (up) begin
      sum = {{2{mid[DW-1]}}, mid} + {2'b00, step};
    end else begin
      sum = {{2{mid[DW-1]}}, mid} - {2'b00, step};
    end
    if (sum[DW+1] && !(sum[DW] && sum[DW-1])) begin
      make_trial = DATA_MIN;
    end else if (!sum[DW+1] && (sum[DW] || sum[DW-1])) begin
      make_trial = DATA_MAX;
    end else begin
      make_trial = sum[DW-1:0];
    end
  endfunction

  // Configuration registers.
  logic [WW-1:0] tolerance_q;
  logic [IW-1:0] max_iter_q;
  logic          maximize_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tolerance_q <= WW'(66);
      max_iter_q  <= IW'(100);
      maximize_q  <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        gsm_pkg::REG_TOLERANCE: tolerance_q <= cfg_wdata_i;
        gsm_pkg::REG_MAX_ITER:  max_iter_q  <= cfg_wdata_i[IW-1:0];
        gsm_pkg::REG_MAXIMIZE:  maximize_q  <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // Input register and handshake.
  logic           in_valid_q;
  logic           cmd_q;
  gsm_pkg::data_t blo_q;
  gsm_pkg::data_t bhi_q;
  gsm_pkg::data_t fval_q;
  logic           out_valid_q;
  logic           step_fire;

  assign step_fire  = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || step_fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      cmd_q  <= command_i;
      blo_q  <= bound_low_i;
      bhi_q  <= bound_high_i;
      fval_q <= func_value_i;
    end
  end

  // Search state.
  logic [2:0]       phase_q, phase_d;
  gsm_pkg::data_t   lower_q, lower_d;
  gsm_pkg::data_t   upper_q, upper_d;
  gsm_pkg::data_t   mid_q, mid_d;
  gsm_pkg::data_t   trial_q, trial_d;
  gsm_pkg::data_t   vlow_q, vlow_d;
  gsm_pkg::data_t   vup_q, vup_d;
  gsm_pkg::data_t   vmid_q, vmid_d;
  logic [IW-1:0]    iter_q, iter_d;

  logic             res_fin;
  gsm_pkg::data_t   res_point;
  gsm_pkg::status_e res_status;
  logic [WW-1:0]    res_width;

  gsm_pkg::data_t   f_val;
  logic signed [DW:0] bound_sum;
  gsm_pkg::data_t   new_lo;
  gsm_pkg::data_t   new_mid;
  gsm_pkg::data_t   new_hi;
  logic             no_update;
  logic signed [DW:0] new_span;
  logic [IW-1:0]    iter_inc;
  gsm_pkg::data_t   trial_lo;
  gsm_pkg::data_t   trial_mid;
  gsm_pkg::data_t   trial_hi;
  gsm_pkg::data_t   trial_calc;

  always_comb begin
    if (maximize_q) begin
      f_val = (fval_q == DATA_MIN) ? DATA_MAX : -fval_q;
    end else begin
      f_val = fval_q;
    end
    bound_sum = {blo_q[DW-1], blo_q} + {bhi_q[DW-1], bhi_q};

    new_lo    = lower_q;
    new_mid   = mid_q;
    new_hi    = upper_q;
    vlow_d    = vlow_q;
    vup_d     = vup_q;
    vmid_d    = vmid_q;
    no_update = 1'b0;
    priority if (f_val < vmid_q) begin
      new_mid = trial_q;
      vmid_d  = f_val;
    end else if (trial_q < mid_q && f_val < vlow_q) begin
      new_lo = trial_q;
      vlow_d = f_val;
    end else if (trial_q > mid_q && f_val < vup_q) begin
      new_hi = trial_q;
      vup_d  = f_val;
    end else begin
      no_update = 1'b1;
    end
    new_span = {new_hi[DW-1], new_hi} - {new_lo[DW-1], new_lo};
    iter_inc = iter_q + IW'(1);

    if (phase_q == PH_WANT_MID) begin
      trial_lo  = lower_q;
      trial_mid = mid_q;
      trial_hi  = upper_q;
    end else begin
      trial_lo  = new_lo;
      trial_mid = new_mid;
      trial_hi  = new_hi;
    end
    trial_calc = make_trial(trial_lo, trial_mid, trial_hi);

    phase_d    = phase_q;
    lower_d    = lower_q;
    upper_d    = upper_q;
    mid_d      = mid_q;
    trial_d    = trial_q;
    iter_d     = iter_q;
    res_fin    = 1'b0;
    res_point  = '0;
    res_status = gsm_pkg::ST_CONVERGED;
    res_width  = '0;

    if (cmd_q == gsm_pkg::command_start) begin
      vlow_d = vlow_q;
      vup_d  = vup_q;
      vmid_d = vmid_q;
      if (blo_q > bhi_q || tolerance_q == '0) begin
        phase_d    = PH_IDLE;
        res_fin    = 1'b1;
        res_status = gsm_pkg::ST_INVALID;
      end else begin
        lower_d   = blo_q;
        upper_d   = bhi_q;
        mid_d     = bound_sum[DW:1];
        phase_d   = PH_WANT_LOW;
        res_point = blo_q;
        res_width = sat_width(blo_q, bhi_q);
      end
    end else begin
      unique case (phase_q)
        PH_WANT_LOW: begin
          vlow_d    = f_val;
          vup_d     = vup_q;
          vmid_d    = vmid_q;
          phase_d   = PH_WANT_HIGH;
          res_point = upper_q;
          res_width = sat_width(lower_q, upper_q);
        end
        PH_WANT_HIGH: begin
          vlow_d    = vlow_q;
          vup_d     = f_val;
          vmid_d    = vmid_q;
          phase_d   = PH_WANT_MID;
          res_point = mid_q;
          res_width = sat_width(lower_q, upper_q);
        end
        PH_WANT_MID: begin
          vlow_d    = vlow_q;
          vup_d     = vup_q;
          vmid_d    = f_val;
          iter_d    = '0;
          trial_d   = trial_calc;
          phase_d   = PH_WANT_TRIAL;
          res_point = trial_d;
          res_width = sat_width(lower_q, upper_q);
        end
        PH_WANT_TRIAL: begin
          if (no_update) begin
            phase_d    = PH_IDLE;
            res_fin    = 1'b1;
            res_point  = mid_q;
            res_status = gsm_pkg::ST_NOT_UNIMODAL;
            res_width  = sat_width(lower_q, upper_q);
          end else begin
            lower_d   = new_lo;
            upper_d   = new_hi;
            mid_d     = new_mid;
            res_width = sat_width(new_lo, new_hi);
            if (new_span <= $signed({2'b00, tolerance_q})) begin
              phase_d    = PH_IDLE;
              res_fin    = 1'b1;
              res_point  = new_mid;
              res_status = (iter_q != max_iter_q) ? gsm_pkg::ST_CONVERGED
                                                  : gsm_pkg::ST_ITER_LIMIT;
            end else if (iter_inc == max_iter_q) begin
              iter_d     = iter_inc;
              phase_d    = PH_IDLE;
              res_fin    = 1'b1;
              res_point  = new_mid;
              res_status = gsm_pkg::ST_ITER_LIMIT;
            end else begin
              iter_d    = iter_inc;
              trial_d   = trial_calc;
              res_point = trial_d;
            end
          end
        end
        default: begin
          vlow_d     = vlow_q;
          vup_d      = vup_q;
          vmid_d     = vmid_q;
          phase_d    = PH_IDLE;
          res_fin    = 1'b1;
          res_status = gsm_pkg::ST_NO_SEARCH;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      lower_q <= '0;
      upper_q <= '0;
      mid_q   <= '0;
      trial_q <= '0;
      vlow_q  <= '0;
      vup_q   <= '0;
      vmid_q  <= '0;
      iter_q  <= '0;
    end else if (step_fire) begin
      phase_q <= phase_d;
      lower_q <= lower_d;
      upper_q <= upper_d;
      mid_q   <= mid_d;
      trial_q <= trial_d;
      vlow_q  <= vlow_d;
      vup_q   <= vup_d;
      vmid_q  <= vmid_d;
      iter_q  <= iter_d;
    end
  end

  // Result register.
  logic             fin_q;
  gsm_pkg::data_t   point_q;
  gsm_pkg::status_e status_q;
  logic [WW-1:0]    width_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_fire) begin
      fin_q    <= res_fin;
      point_q  <= res_point;
      status_q <= res_status;
      width_q  <= res_width;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign finished_o       = fin_q;
  assign point_o          = point_q;
  assign status_o         = status_q;
  assign interval_width_o = width_q;

  `GSM_ASSERT_IMP(a_request_has_zero_status, out_valid_o && !finished_o,
                  status_o == gsm_pkg::ST_CONVERGED)

  `GSM_ASSERT_IMP(a_abort_word_is_blank,
                  out_valid_o && finished_o &&
                  (status_o == gsm_pkg::ST_INVALID || status_o == gsm_pkg::ST_NO_SEARCH),
                  point_o == '0 && interval_width_o == '0)

  `GSM_ASSERT_NXT(a_finish_returns_to_idle, step_fire && res_fin, phase_q == PH_IDLE)

  `GSM_ASSERT_IMP(a_middle_inside_interval, phase_q == PH_WANT_TRIAL,
                  lower_q <= mid_q && mid_q <= upper_q)

endmodule

`default_nettype wire

// ===== bench/golden_section_minimizer_tb.sv =====
// ----------------------------------------------------------------------------
// Golden-section minimiser testbench
// Drives start and function-value words into the minimiser and checks each
// result word against a cycle-free predictor of the search. Value words are
// generated from the point that the block is expected to ask for, so that
// most searches run to convergence or the iteration limit. Raw noise and
// broken sequences are mixed in. Registers are rewritten between phases
// while nothing is in flight.
// ----------------------------------------------------------------------------
module golden_section_minimizer_tb;
  import gsm_pkg::*;

  localparam logic CMD_VALUE = 1'b1;
  localparam logic [63:0] GOLDEN_STEP = 64'd1640531527;
  localparam logic signed [63:0] Q_MAX = 64'sd2147483647;
  localparam logic signed [63:0] Q_MIN = -64'sd2147483648;
  localparam int CYCLE_LIMIT = 300000;

  typedef enum logic [1:0] {VAL_RAW, VAL_ABS, VAL_SQUARE} value_shape_e;
  typedef enum logic [2:0] {
    SRCH_IDLE, SRCH_LOWER, SRCH_UPPER, SRCH_MIDDLE, SRCH_TRIAL
  } search_phase_e;

  typedef struct {
    logic                command;
    logic signed [31:0]  lo;
    logic signed [31:0]  hi;
    logic signed [31:0]  value;
    value_shape_e        shape;
    logic signed [63:0]  centre;
    logic                follow;
  } pending_word_t;

  typedef struct packed {
    logic        finished;
    logic [31:0] point;
    status_e     status;
    logic [30:0] width;
  } result_word_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index_i = '0;
  logic [WIDTH_W-1:0] cfg_wdata_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic command_i = 1'b0;
  logic signed [DATA_W-1:0] bound_low_i = '0;
  logic signed [DATA_W-1:0] bound_high_i = '0;
  logic signed [DATA_W-1:0] func_value_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic finished_o;
  logic signed [DATA_W-1:0] point_o;
  logic [2:0] status_o;
  logic [WIDTH_W-1:0] interval_width_o;

  golden_section_minimizer dut (.*);

  // Predictor state and its copy of the registers.
  logic [30:0] tol_reg = 31'd66;
  logic [15:0] iter_limit = 16'd100;
  logic maximise_reg = 1'b0;
  search_phase_e search_phase = SRCH_IDLE;
  logic signed [63:0] lo_end = '0, hi_end = '0, mid_pt = '0, trial_pt = '0;
  logic signed [63:0] f_lo = '0, f_hi = '0, f_mid = '0;
  logic [15:0] iter_cnt = '0;

  pending_word_t outgoing_words[$];
  result_word_t predicted_replies[$];
  pending_word_t nxt;
  result_word_t predicted, oldest;
  logic signed [31:0] asked_pt = '0;
  logic in_fire = 1'b0;
  logic calm = 1'b0;
  int errors = 0;
  int cycle_cnt = 0;
  int sent_cnt = 0;

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  function automatic logic signed [63:0] clamp32(input logic signed [63:0] v);
    if (v > Q_MAX) return Q_MAX;
    if (v < Q_MIN) return Q_MIN;
    return v;
  endfunction

  function automatic logic [30:0] span_now();
    logic signed [63:0] w;
    w = hi_end - lo_end;
    if (w < 0) return '0;
    if (w > Q_MAX) return 31'h7fff_ffff;
    return w[30:0];
  endfunction

  function automatic result_word_t result_of(input logic fin, input logic signed [63:0] pt,
                                             input status_e st, input logic [30:0] w);
    result_word_t r;
    r.finished = fin;
    r.point = pt[31:0];
    r.status = st;
    r.width = w;
    return r;
  endfunction

  // Next trial point: golden fraction of the larger half, rounded to nearest.
  task automatic place_trial();
    logic signed [63:0] wl, wu, delta;
    logic [63:0] mag, prod;
    logic up;
    wl = mid_pt - lo_end;
    wu = hi_end - mid_pt;
    up = wu > wl;
    mag = up ? wu : wl;
    prod = mag * GOLDEN_STEP + 64'h8000_0000;
    delta = $signed({32'd0, prod[63:32]});
    trial_pt = clamp32(up ? mid_pt + delta : mid_pt - delta);
  endtask

  task automatic golden_step(input logic cmd, input logic signed [31:0] lo_in,
                             input logic signed [31:0] hi_in, input logic signed [31:0] val_in,
                             output result_word_t r);
    logic signed [63:0] a, b, s, f, tol_s;
    a = lo_in;
    b = hi_in;
    tol_s = {33'd0, tol_reg};
    if (cmd == command_start) begin
      if (a > b || tol_reg == '0) begin
        search_phase = SRCH_IDLE;
        r = result_of(1'b1, 64'sd0, ST_INVALID, '0);
      end else begin
        lo_end = a;
        hi_end = b;
        s = a + b;
        mid_pt = (s - (s & 64'sd1)) >>> 1;
        search_phase = SRCH_LOWER;
        r = result_of(1'b0, lo_end, ST_CONVERGED, span_now());
      end
      return;
    end
    f = val_in;
    if (maximise_reg) f = clamp32(-f);
    case (search_phase)
      SRCH_LOWER: begin
        f_lo = f;
        search_phase = SRCH_UPPER;
        r = result_of(1'b0, hi_end, ST_CONVERGED, span_now());
      end
      SRCH_UPPER: begin
        f_hi = f;
        search_phase = SRCH_MIDDLE;
        r = result_of(1'b0, mid_pt, ST_CONVERGED, span_now());
      end
      SRCH_MIDDLE: begin
        f_mid = f;
        iter_cnt = '0;
        place_trial();
        search_phase = SRCH_TRIAL;
        r = result_of(1'b0, trial_pt, ST_CONVERGED, span_now());
      end
      SRCH_TRIAL: begin
        if (f < f_mid) begin
          mid_pt = trial_pt;
          f_mid = f;
        end else if (trial_pt < mid_pt && f < f_lo) begin
          lo_end = trial_pt;
          f_lo = f;
        end else if (trial_pt > mid_pt && f < f_hi) begin
          hi_end = trial_pt;
          f_hi = f;
        end else begin
          search_phase = SRCH_IDLE;
          r = result_of(1'b1, mid_pt, ST_NOT_UNIMODAL, span_now());
          return;
        end
        if (hi_end - lo_end <= tol_s) begin
          search_phase = SRCH_IDLE;
          r = result_of(1'b1, mid_pt, (iter_cnt != iter_limit) ? ST_CONVERGED : ST_ITER_LIMIT,
                        span_now());
        end else begin
          iter_cnt = iter_cnt + 16'd1;
          if (iter_cnt == iter_limit) begin
            search_phase = SRCH_IDLE;
            r = result_of(1'b1, mid_pt, ST_ITER_LIMIT, span_now());
          end else begin
            place_trial();
            r = result_of(1'b0, trial_pt, ST_CONVERGED, span_now());
          end
        end
      end
      default: begin
        search_phase = SRCH_IDLE;
        r = result_of(1'b1, 64'sd0, ST_NO_SEARCH, '0);
      end
    endcase
  endtask

  // A unimodal test function around the centre, taken at the point last asked for.
  function automatic logic signed [31:0] value_at(input value_shape_e shape,
                                                  input logic signed [63:0] centre);
    logic signed [63:0] d;
    logic [63:0] ad, g;
    d = asked_pt - centre;
    ad = (d < 0) ? -d : d;
    if (shape == VAL_ABS) g = ad;
    else g = (ad > 64'd268435456) ? 64'hffff_ffff : (ad * ad) >> 24;
    if (g > 64'd2147483647) g = 64'd2147483647;
    return maximise_reg ? -g[31:0] : g[31:0];
  endfunction

  function automatic logic signed [31:0] rand_q();
    return $urandom;
  endfunction

  task automatic push_word(input logic cmd, input logic signed [31:0] lo_v,
                           input logic signed [31:0] hi_v, input logic signed [31:0] val_v,
                           input value_shape_e shape_v = VAL_RAW,
                           input logic signed [63:0] centre_v = 64'sd0,
                           input logic follow_v = 1'b0);
    pending_word_t w;
    w.command = cmd;
    w.lo = lo_v;
    w.hi = hi_v;
    w.value = val_v;
    w.shape = shape_v;
    w.centre = centre_v;
    w.follow = follow_v;
    outgoing_words.push_back(w);
  endtask

  task automatic push_search();
    logic signed [63:0] a, b, c, t;
    logic [63:0] r64;
    value_shape_e shape;
    int n;
    a = rand_q();
    b = rand_q();
    case ($urandom_range(3))
      0: if (a > b) begin
        t = a;
        a = b;
        b = t;
      end
      1: b = clamp32(a + $urandom_range(5000));
      2: b = clamp32(a + ($urandom & 32'h00ff_ffff));
      default: ;
    endcase
    r64 = {$urandom, $urandom};
    if (b >= a && $urandom_range(7) != 0) c = a + r64 % (b - a + 1);
    else c = rand_q();
    case ($urandom_range(9))
      0: shape = VAL_RAW;
      1, 2, 3, 4, 5: shape = VAL_ABS;
      default: shape = VAL_SQUARE;
    endcase
    push_word(command_start, a[31:0], b[31:0], rand_q());
    n = $urandom_range(40, 3);
    repeat (n) push_word(CMD_VALUE, rand_q(), rand_q(), rand_q(), shape, c, 1'b1);
  endtask

  task automatic fill_random(input int target);
    @(posedge clk_i);
    while (outgoing_words.size() < target) begin
      if ($urandom_range(9) == 0) push_word(1'($urandom_range(1)), rand_q(), rand_q(), rand_q());
      else push_search();
    end
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [30:0] data);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= data;
    case (idx)
      REG_TOLERANCE: tol_reg = data;
      REG_MAX_ITER:  iter_limit = data[15:0];
      REG_MAXIMIZE:  maximise_reg = data[0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic configure(input logic [30:0] tol, input logic [15:0] max_it, input logic mode);
    write_reg(REG_TOLERANCE, tol);
    write_reg(REG_MAX_ITER, 31'(max_it));
    write_reg(REG_MAXIMIZE, 31'(mode));
  endtask

  task automatic settle();
    do @(posedge clk_i);
    while (!(outgoing_words.size() == 0 && !in_valid_i && predicted_replies.size() == 0));
    repeat (4) @(posedge clk_i);
  endtask

  function automatic logic [30:0] rand_tol();
    case ($urandom_range(2))
      0: return 31'($urandom_range(100, 1));
      1: return 31'($urandom_range(1 << 20, 1));
      default: return 31'($urandom_range(32'h7fff_ffff, 1));
    endcase
  endfunction

  // Driver: words change on the falling edge only.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid_i || in_fire) begin
        while (outgoing_words.size() > 0 && outgoing_words[0].follow &&
               search_phase == SRCH_IDLE)
          void'(outgoing_words.pop_front());
        if (outgoing_words.size() > 0 && (calm || $urandom_range(99) >= 9)) begin
          nxt = outgoing_words.pop_front();
          in_valid_i <= 1'b1;
          command_i <= nxt.command;
          bound_low_i <= nxt.lo;
          bound_high_i <= nxt.hi;
          func_value_i <= (nxt.shape == VAL_RAW) ? nxt.value : value_at(nxt.shape, nxt.centre);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      out_ready_i <= calm || ($urandom_range(99) >= 9);
    end
  end

  // Monitor: predicts on every accepted word and checks every result word.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    in_fire <= rst_ni && in_valid_i && in_ready_o;
    if (rst_ni && in_valid_i && in_ready_o) begin
      sent_cnt <= sent_cnt + 1;
      golden_step(command_i, bound_low_i, bound_high_i, func_value_i, predicted);
      asked_pt = predicted.point;
      predicted_replies.push_back(predicted);
    end
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (predicted_replies.size() == 0) begin
        $error("result word with nothing pending: point %0d status %0d", point_o, status_o);
        errors++;
      end else begin
        oldest = predicted_replies.pop_front();
        if (finished_o !== oldest.finished) begin
          $error("finished: expected %0d, got %0d", oldest.finished, finished_o);
          errors++;
        end
        if (point_o !== oldest.point) begin
          $error("point: expected %0d, got %0d", $signed(oldest.point), point_o);
          errors++;
        end
        if (status_o !== oldest.status) begin
          $error("status: expected %0d, got %0d", oldest.status, status_o);
          errors++;
        end
        if (interval_width_o !== oldest.width) begin
          $error("interval_width: expected %0d, got %0d", oldest.width, interval_width_o);
          errors++;
        end
      end
    end
  end

  initial begin
    while (cycle_cnt < CYCLE_LIMIT) @(posedge clk_i);
    $display("golden_section_minimizer verification failed");
    $finish;
  end

  initial begin
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Values with no search running, then reversed bounds.
    push_word(CMD_VALUE, 0, 0, 32'sd0);
    push_word(CMD_VALUE, 0, 0, 32'h8000_0000);
    push_word(command_start, 32'sd5, 32'sd4, 0);
    // Full-range interval, abandoned by a fresh start part way through.
    push_word(command_start, 32'h8000_0000, 32'h7fff_ffff, 0);
    push_word(CMD_VALUE, 0, 0, 32'h7fff_ffff);
    push_word(CMD_VALUE, 0, 0, 32'h7fff_ffff);
    push_word(CMD_VALUE, 0, 0, 32'h8000_0000);
    push_word(CMD_VALUE, 0, 0, 32'sd0);
    // A trial point equal to the midpoint with no improvement is not unimodal.
    push_word(command_start, -32'sd1, 32'sd1, 0);
    push_word(CMD_VALUE, 0, 0, 32'sh1000);
    push_word(CMD_VALUE, 0, 0, 32'sh1000);
    push_word(CMD_VALUE, 0, 0, 32'sd0);
    push_word(CMD_VALUE, 0, 0, 32'sd0);
    // Zero-width intervals converge on the first improvement.
    push_word(command_start, 32'sd0, 32'sd0, 0);
    repeat (3) push_word(CMD_VALUE, 0, 0, 32'sd5);
    push_word(CMD_VALUE, 0, 0, -32'sd1);
    push_word(command_start, 32'h7fff_ffff, 32'h7fff_ffff, 0);
    repeat (3) push_word(CMD_VALUE, 0, 0, 32'h7fff_ffff);
    push_word(CMD_VALUE, 0, 0, 32'sd0);
    settle();

    configure('0, 16'd100, 1'b0);
    fill_random(40);
    settle();

    configure(31'd1, 16'hffff, 1'b0);
    fill_random(150);
    settle();

    configure(31'd66, 16'd3, 1'b1);
    @(posedge clk_i);
    // Negating the most negative value saturates.
    push_word(command_start, 32'sd0, 32'sh10000, 0);
    push_word(CMD_VALUE, 0, 0, 32'h8000_0000);
    push_word(CMD_VALUE, 0, 0, 32'h7fff_ffff);
    push_word(CMD_VALUE, 0, 0, 32'sd0);
    fill_random(150);
    settle();

    configure(31'h7fff_ffff, 16'd1, 1'b0);
    fill_random(150);
    settle();

    configure(rand_tol(), 16'd0, 1'b1);
    fill_random(150);
    settle();

    // Searches that end early drop their queued words, so keep going until enough were sent.
    for (int k = 0; k < 40 && (k < 4 || sent_cnt < 1200); k++) begin
      calm = (k == 1);
      configure(rand_tol(),
                $urandom_range(1) ? 16'($urandom_range(30, 1)) : 16'($urandom_range(65535)),
                1'($urandom_range(1)));
      fill_random(150);
      settle();
    end
    calm = 1'b0;

    repeat (8) @(posedge clk_i);
    if (errors == 0) begin
      $display("golden_section_minimizer verification clean");
    end else begin
      $display("golden_section_minimizer verification failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/gsm_pkg.sv
rtl/golden_section_minimizer.sv
bench/golden_section_minimizer_tb.sv
